// ----- rtl/core/ksm_pkg.sv -----
// shared types, constants and helpers for the k smallest window mean block
package ksm_pkg;

  localparam int MAX_SAMPLES = 8;
  localparam int PIX_W       = 8;
  localparam int CFG_W       = 4;
  localparam int COUNT_W     = 4;
  localparam int COUNT_MAX   = 15;
  localparam int CLEAR_VALUE = 255;
  localparam int CFG_RESET   = 3;
  localparam int K_W         = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SUM_W       = $clog2(MAX_SAMPLES * CLEAR_VALUE + 1);
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] background;
    logic             short_window;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;
    logic sum_en;
    logic div_start;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sum_done;
    logic div_done;
  } ctrl_sts_t;

  // clamp the programmed count into 1..MAX_SAMPLES
  function automatic logic [K_W-1:0] eff_k(logic [CFG_W-1:0] c);
    logic [K_W-1:0] k;
    if (c == '0) begin
      k = K_W'(1);
    end else if (32'(c) > MAX_SAMPLES) begin
      k = K_W'(MAX_SAMPLES);
    end else begin
      k = K_W'(c);
    end
    return k;
  endfunction

endpackage

// ----- rtl/core/ksm_divider.sv -----
// restoring divider, one quotient bit per cycle
module ksm_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ksm_pkg::SUM_W-1:0]  dividend_i,
  input  logic [ksm_pkg::K_W-1:0]    divisor_i,
  output logic                       done_o,
  output logic [ksm_pkg::SUM_W-1:0]  quotient_o
);

  logic [ksm_pkg::SUM_W-1:0]     dvd_q, dvd_d;
  logic [ksm_pkg::K_W-1:0]       rem_q, rem_d;
  logic [ksm_pkg::K_W-1:0]       dsr_q, dsr_d;
  logic [ksm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [ksm_pkg::K_W:0]         trial;
  logic                          qbit;

  always_comb begin
    trial  = {rem_q, dvd_q[ksm_pkg::SUM_W-1]};
    qbit   = (trial >= {1'b0, dsr_q});
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = ksm_pkg::DIV_CNT_W'(ksm_pkg::SUM_W);
      run_d = 1'b1;
    end else if (run_q) begin
      // quotient bits shift in where the dividend shifts out
      dvd_d = {dvd_q[ksm_pkg::SUM_W-2:0], qbit};
      rem_d = qbit ? ksm_pkg::K_W'(trial - {1'b0, dsr_q})
                   : ksm_pkg::K_W'(trial);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ksm_pkg::DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- rtl/core/ksm_datapath.sv -----
// sorted k smallest store, accumulator, divider and result register
module ksm_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ksm_pkg::item_t             item_i,
  input  logic                       cfg_we_i,
  input  logic [ksm_pkg::CFG_W-1:0]  cfg_data_i,
  input  ksm_pkg::ctrl_cmd_t         cmd_i,
  output ksm_pkg::ctrl_sts_t         sts_o,
  output logic                       done_o,
  output ksm_pkg::result_t           result_o
);

  logic [ksm_pkg::PIX_W-1:0]   vals_q [ksm_pkg::MAX_SAMPLES];
  logic [ksm_pkg::PIX_W-1:0]   vals_ins [ksm_pkg::MAX_SAMPLES];
  logic [ksm_pkg::COUNT_W-1:0] count_q, count_inc;
  logic [ksm_pkg::CFG_W-1:0]   cfg_q;
  logic [ksm_pkg::K_W-1:0]     k_q, k_now;
  logic [ksm_pkg::IDX_W-1:0]   idx_q;
  logic [ksm_pkg::SUM_W-1:0]   sum_q;
  logic                        short_q;
  logic                        valid_q;
  ksm_pkg::result_t            result_q;
  logic                        div_done;
  logic [ksm_pkg::SUM_W-1:0]   quotient;

  // insert the new pixel into the ascending list, every slot in parallel
  always_comb begin
    if (vals_q[0] <= item_i.pixel) begin
      vals_ins[0] = vals_q[0];
    end else begin
      vals_ins[0] = item_i.pixel;
    end
    for (int i = 1; i < ksm_pkg::MAX_SAMPLES; i++) begin
      if (vals_q[i] <= item_i.pixel) begin
        vals_ins[i] = vals_q[i];
      end else if (vals_q[i-1] <= item_i.pixel) begin
        vals_ins[i] = item_i.pixel;
      end else begin
        vals_ins[i] = vals_q[i-1];
      end
    end
  end

  assign count_inc = (32'(count_q) < ksm_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;
  // a write landing with the last pixel already counts for that window
  assign k_now     = ksm_pkg::eff_k(cfg_we_i ? cfg_data_i : cfg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ksm_pkg::MAX_SAMPLES; i++) begin
        vals_q[i] <= ksm_pkg::PIX_W'(ksm_pkg::CLEAR_VALUE);
      end
      count_q <= '0;
      cfg_q   <= ksm_pkg::CFG_W'(ksm_pkg::CFG_RESET);
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        for (int i = 0; i < ksm_pkg::MAX_SAMPLES; i++) begin
          vals_q[i] <= ksm_pkg::PIX_W'(ksm_pkg::CLEAR_VALUE);
        end
        count_q <= '0;
      end else if (cmd_i.take_item) begin
        vals_q  <= vals_ins;
        count_q <= count_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && item_i.last) begin
      k_q     <= k_now;
      short_q <= (32'(count_inc) < 32'(k_now));
      sum_q   <= '0;
      idx_q   <= '0;
    end else if (cmd_i.sum_en) begin
      sum_q <= sum_q + ksm_pkg::SUM_W'(vals_q[idx_q]);
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.finish) begin
      result_q.background   <= quotient[ksm_pkg::PIX_W-1:0];
      result_q.short_window <= short_q;
    end
  end

  ksm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (k_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign sts_o.sum_done = ((32'(idx_q) + 1) == 32'(k_q));
  assign sts_o.div_done = div_done;
  assign done_o         = valid_q;
  assign result_o       = result_q;

endmodule

// ----- rtl/core/ksm_ctrl.sv -----
// sequencing state machine: take pixels, sum k values, divide, deliver
module ksm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               last_i,
  input  ksm_pkg::ctrl_sts_t sts_i,
  output ksm_pkg::ctrl_cmd_t cmd_o,
  output logic               busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_LOAD = 4'b0100,
    S_DIV  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy            = 1'b0;
        cmd_o.take_item = start;
        if (start && last_i) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        if (sts_i.sum_done) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/k_smallest_window_mean.sv -----
// top level of the k smallest window mean background estimator
//
// pixels of one window arrive one per transfer (start high while busy is
// low), the final pixel flagged by last; the block keeps the smallest
// values of the window in ascending order and, after the last pixel, gives
// the floor mean of the k smallest (k from sample_count, clamped to
// 1..MAX_SAMPLES) on result_o with done_o high for exactly one cycle;
// the receiver cannot stall, so the result must be taken in that cycle.
// a pixel without last is taken while busy stays low; after a last
// pixel busy is high while the one-add accumulator sums the k smallest
// values, the divider is loaded, the bit-serial divider works out all
// SUM_W quotient bits and the result is handed off; the result strobe
// shows in the cycle busy drops, and the next window's first pixel may
// be taken in that same cycle. sample_count is to be written through
// cfg_we_i / cfg_data_i only while idle; the block does not enforce it.
module k_smallest_window_mean (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  ksm_pkg::item_t            item_i,
  output logic                      busy,
  input  logic                      cfg_we_i,
  input  logic [ksm_pkg::CFG_W-1:0] cfg_data_i,
  output logic                      done_o,
  output ksm_pkg::result_t          result_o
);

  // command and status between sequencer and datapath
  ksm_pkg::ctrl_cmd_t cmd;
  ksm_pkg::ctrl_sts_t sts;

  // sequencer: idle pixel intake, then accumulate, load and divide
  ksm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .last_i (item_i.last),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // datapath: sorted store, pixel count, sum, divider, result register
  ksm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

// ----- tb/ksm_window_checker.sv -----
// checker for the k smallest window mean block: predicts each window mean and compares results
`timescale 1ns / 100ps

module ksm_window_checker
  import ksm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  item_t            item_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             done_o,
  input  result_t          result_o,
  output int               fail_count_o,
  output int               pending_o
);

  // predicted window contents, ascending
  logic [PIX_W-1:0]   held_min [MAX_SAMPLES];
  logic [COUNT_W-1:0] window_count;
  logic [CFG_W-1:0]   k_setting;
  result_t            mean_expected [$];

  function automatic int clamp_k(logic [CFG_W-1:0] c);
    if (c == '0) return 1;
    if (int'(c) > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(c);
  endfunction

  task automatic clear_window();
    for (int i = 0; i < MAX_SAMPLES; i++) held_min[i] = PIX_W'(CLEAR_VALUE);
    window_count = '0;
  endtask

  task automatic take_pixel(item_t it);
    int      pos;
    int      k;
    int      sum;
    result_t r;
    // sorted insert, dropping the largest held value
    if (it.pixel < held_min[MAX_SAMPLES-1]) begin
      pos = MAX_SAMPLES - 1;
      while (pos > 0 && held_min[pos-1] > it.pixel) begin
        held_min[pos] = held_min[pos-1];
        pos--;
      end
      held_min[pos] = it.pixel;
    end
    if (window_count < COUNT_W'(COUNT_MAX)) window_count++;
    if (it.last) begin
      k   = clamp_k(k_setting);
      sum = 0;
      for (int i = 0; i < k; i++) sum += int'(held_min[i]);
      r.background   = PIX_W'(sum / k);
      r.short_window = (int'(window_count) < k);
      mean_expected.push_back(r);
      clear_window();
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (mean_expected.size() == 0) begin
      $error("unexpected result: background %0d short_window %0d",
             got.background, got.short_window);
      fail_count_o++;
    end else begin
      want = mean_expected.pop_front();
      if (got.background !== want.background) begin
        $error("background: expected %0d, actual %0d", want.background, got.background);
        fail_count_o++;
      end
      if (got.short_window !== want.short_window) begin
        $error("short_window: expected %0d, actual %0d",
               want.short_window, got.short_window);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_window();
      k_setting = CFG_W'(CFG_RESET);
      mean_expected.delete();
      fail_count_o = 0;
    end else begin
      if (done_o) check_result(result_o);
      if (cfg_we_i) k_setting = cfg_data_i;
      if (start && !busy) take_pixel(item_i);
    end
    pending_o = mean_expected.size();
  end

endmodule

// ----- tb/tb_k_smallest_window_mean.sv -----
// testbench top for the k smallest window mean block: stimulus, configuration and verdict
`timescale 1ns / 100ps

module tb_k_smallest_window_mean;
  import ksm_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  // the random run of at least 700 pixels, with busy stretches and gaps, stays well under this
  localparam int CYCLE_LIMIT   = 400000;
  // margin longer than the longest busy stretch after a last pixel
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 700;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             start      = 1'b0;
  item_t            item_i     = '0;
  logic             cfg_we_i   = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             busy;
  logic             done_o;
  result_t          result_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  // set for the stretch where the sender never pauses
  bit no_gaps     = 1'b0;

  always #CLK_HALF clk_i = ~clk_i;

  k_smallest_window_mean dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .item_i     (item_i),
    .busy       (busy),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  ksm_window_checker window_mean_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .result_o     (result_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // hard stop in case the block hangs or a result never shows
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[k_smallest_window_mean] ERROR");
      $finish;
    end
  end

  // one pixel transfer; called and returns at a falling edge
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic last);
    int gap;
    gap = 0;
    // random pauses, each cycle idle with odds of about 27 in a hundred
    if (!no_gaps) begin
      while ($urandom_range(99) < 27) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{pixel: pix, last: last};
    // busy seen here is the value the edge acted on
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // register write only with the block idle and all window means collected
  task automatic write_sample_count(logic [CFG_W-1:0] k);
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= k;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // pixel flavors: full range, the extremes, dark band, bright band
  function automatic logic [PIX_W-1:0] pick_pixel(int style);
    logic [PIX_W-1:0] p;
    case (style)
      1: begin
        case ($urandom_range(3))
          0: p = 8'd0;
          1: p = 8'd1;
          2: p = 8'd254;
          default: p = 8'd255;
        endcase
      end
      2: p = PIX_W'($urandom_range(15));
      3: p = PIX_W'(240 + $urandom_range(15));
      default: p = PIX_W'($urandom_range(255));
    endcase
    return p;
  endfunction

  // mostly short windows so short_window shows for large k, some long ones
  // to drive the pixel count into saturation
  function automatic int pick_window_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 1;
    if (r < 80) return $urandom_range(2, 9);
    if (r < 92) return $urandom_range(10, 15);
    return $urandom_range(16, 22);
  endfunction

  initial begin
    int               phase;
    int               sent_total;
    int               phase_items;
    int               phase_sent;
    int               len;
    int               style;
    logic [CFG_W-1:0] k_next;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset value of k (3): mixed extremes, full window
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd0,   1'b0);
    send_pixel(8'd255, 1'b1);
    // single pixel window, fewer pixels than k
    send_pixel(8'd17, 1'b1);

    // k of zero acts as one
    write_sample_count(4'd0);
    send_pixel(8'd9, 1'b0);
    send_pixel(8'd4, 1'b1);

    // k above the slot count acts as the full slot count; short window too
    write_sample_count(4'd15);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd2, 1'b0);
    send_pixel(8'd3, 1'b1);

    // full k, interleaved values exercise the sorted insert and dropping
    write_sample_count(4'd8);
    send_pixel(8'd250, 1'b0);
    send_pixel(8'd10,  1'b0);
    send_pixel(8'd240, 1'b0);
    send_pixel(8'd20,  1'b0);
    send_pixel(8'd230, 1'b0);
    send_pixel(8'd30,  1'b0);
    send_pixel(8'd220, 1'b0);
    send_pixel(8'd40,  1'b0);
    send_pixel(8'd5,   1'b1);

    // smallest k with the top value
    write_sample_count(4'd1);
    send_pixel(8'd255, 1'b1);

    // k changed while a window is open takes effect at its last pixel
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd50,  1'b0);
    write_sample_count(4'd2);
    send_pixel(8'd60, 1'b1);

    // random phases, each closing on a last pixel before the next k setting
    sent_total = 0;
    phase      = 0;
    while (sent_total < RANDOM_ITEMS) begin
      case (phase)
        0: k_next = 4'd1;
        1: k_next = 4'd8;
        2: k_next = 4'd0;
        3: k_next = 4'd15;
        default: k_next = CFG_W'($urandom_range(15));
      endcase
      write_sample_count(k_next);
      // one whole phase back to back with no pauses
      no_gaps     = (phase == 1);
      phase_items = $urandom_range(60, 100);
      phase_sent  = 0;
      while (phase_sent < phase_items) begin
        len   = pick_window_len();
        style = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          send_pixel(pick_pixel(style), (i == len - 1));
        end
        phase_sent += len;
      end
      sent_total += phase_sent;
      phase++;
    end
    no_gaps = 1'b0;

    // drain: every window mean in, then a margin for stray strobes
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("[k_smallest_window_mean] OK");
    end else begin
      $display("[k_smallest_window_mean] ERROR");
    end
    $finish;
  end

endmodule
